/* rtl/core/cmap4_pkg.sv */
// cmap4_pkg: shared types and constants for the cmap format 4 glyph lookup
// used by the controller, the datapath and the top level; no dependencies

package cmap4_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = 9;
  localparam int GLYPH_WORDS  = 4096;
  localparam int GLYPH_AW     = $clog2(GLYPH_WORDS);
  localparam int IDX_W        = 18;
  localparam int CODE_W       = 21;

  localparam logic [1:0] KIND_LOAD_SEG  = 2'd0;
  localparam logic [1:0] KIND_LOAD_WORD = 2'd1;
  localparam logic [1:0] KIND_LOOKUP    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_FETCH,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] delta;
    logic [15:0] range;
  } seg_entry_t;

  typedef struct packed {
    logic load_en;
    logic lookup_start;
    logic scan_en;
    logic calc_en;
    logic fetch_en;
    logic res_nomatch;
    logic res_delta;
    logic res_err;
    logic res_glyph;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic r_zero;
    logic idx_bad;
  } dp_stat_t;

endpackage

/* rtl/core/cmap4_ctrl.sv */
// cmap4_ctrl: sequencer for load and lookup transactions
// depends on cmap4_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t

module cmap4_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  input  cmap4_pkg::dp_stat_t stat,
  output cmap4_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import cmap4_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_en = 1'b1;
          if (kind == KIND_LOOKUP) begin
            cmd.lookup_start = 1'b1;
            state_next       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        // a hit on the last segment wins over the end of the scan
        if (stat.hit) begin
          state_next = S_CALC;
        end else if (stat.miss) begin
          cmd.res_nomatch = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_CALC: begin
        cmd.calc_en = 1'b1;
        if (stat.r_zero) begin
          cmd.res_delta = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.idx_bad) begin
          cmd.res_err = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.fetch_en = 1'b1;
          state_next   = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.res_glyph = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/cmap4_dp.sv */
// cmap4_dp: segment and glyph memories, scan pointer, index arithmetic, result regs
// depends on cmap4_pkg; controlled by cmap4_ctrl

module cmap4_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  cmap4_pkg::dp_cmd_t   cmd,
  output cmap4_pkg::dp_stat_t  stat,
  input  logic [1:0]           kind,
  input  logic [11:0]          slot,
  input  logic [20:0]          code,
  input  logic [15:0]          seg_start,
  input  logic [15:0]          seg_end,
  input  logic signed [15:0]   seg_delta,
  input  logic [15:0]          seg_range_offset,
  input  logic [15:0]          glyph_word,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  output logic [15:0]          glyph_index,
  output logic                 matched,
  output logic                 index_error
);
  import cmap4_pkg::*;

  seg_entry_t  seg_mem [MAX_SEGMENTS];
  logic [15:0] glyph_mem [GLYPH_WORDS];

  logic [CNT_W-1:0]  seg_count;
  logic [CNT_W-1:0]  count_q;
  logic [CODE_W-1:0] code_q;
  logic [CNT_W-1:0]  rd_idx;
  logic              dv;
  logic [SEG_AW-1:0] cmp_idx;
  seg_entry_t        seg_rd;
  logic [15:0]       h_start;
  logic [15:0]       h_delta;
  logic [15:0]       h_range;
  logic [SEG_AW-1:0] h_idx;
  logic [IDX_W-1:0]  idx_q;
  logic [15:0]       glyph_rd;
  logic              in_range;
  logic [15:0]       code_off;
  logic              rd_go;

  assign in_range = (code_q >= CODE_W'(seg_rd.lo)) && (code_q <= CODE_W'(seg_rd.hi));
  assign rd_go    = rd_idx < count_q;
  assign code_off = code_q[15:0] - h_start;

  assign stat.hit     = dv && in_range;
  assign stat.miss    = (count_q == '0) ||
                        (dv && !in_range && (CNT_W'(cmp_idx) == count_q - CNT_W'(1)));
  assign stat.r_zero  = (h_range == 16'd0);
  assign stat.idx_bad = idx_q[IDX_W-1] || (idx_q >= IDX_W'(GLYPH_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
      dv        <= 1'b0;
      rd_idx    <= '0;
    end else begin
      if (cfg_we) begin
        seg_count <= cfg_data;
      end
      if (cmd.lookup_start) begin
        rd_idx <= '0;
        dv     <= 1'b0;
      end else if (cmd.scan_en) begin
        if (rd_go) begin
          rd_idx <= rd_idx + CNT_W'(1);
          dv     <= 1'b1;
        end else begin
          dv <= 1'b0;
        end
      end
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_en && kind == KIND_LOAD_SEG && 32'(slot) < MAX_SEGMENTS) begin
      seg_mem[slot[SEG_AW-1:0]] <= '{lo: seg_start, hi: seg_end,
                                     delta: seg_delta, range: seg_range_offset};
    end
    if (cmd.load_en && kind == KIND_LOAD_WORD && 32'(slot) < GLYPH_WORDS) begin
      glyph_mem[slot[GLYPH_AW-1:0]] <= glyph_word;
    end
    if (cmd.scan_en && rd_go) begin
      seg_rd <= seg_mem[rd_idx[SEG_AW-1:0]];
    end
    if (cmd.fetch_en) begin
      glyph_rd <= glyph_mem[idx_q[GLYPH_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_start) begin
      code_q  <= code;
      count_q <= (seg_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : seg_count;
    end
    if (cmd.scan_en) begin
      cmp_idx <= rd_idx[SEG_AW-1:0];
    end
    if (cmd.scan_en && stat.hit) begin
      h_start <= seg_rd.lo;
      h_delta <= seg_rd.delta;
      h_range <= seg_rd.range;
      h_idx   <= cmp_idx;
    end
    // array index: range/2 + (code - start) + segment - count
    if (cmd.calc_en) begin
      idx_q <= IDX_W'(h_range[15:1]) + IDX_W'(code_off) + IDX_W'(h_idx) - IDX_W'(count_q);
    end
    if (cmd.res_nomatch) begin
      glyph_index <= 16'd0;
      matched     <= 1'b0;
      index_error <= 1'b0;
    end else if (cmd.res_delta) begin
      glyph_index <= code_q[15:0] + h_delta;
      matched     <= 1'b1;
      index_error <= 1'b0;
    end else if (cmd.res_err) begin
      glyph_index <= 16'd0;
      matched     <= 1'b1;
      index_error <= 1'b1;
    end else if (cmd.res_glyph) begin
      // a zero word means missing glyph and gets no delta
      glyph_index <= (glyph_rd != 16'd0) ? glyph_rd + h_delta : 16'd0;
      matched     <= 1'b1;
      index_error <= 1'b0;
    end
  end

endmodule

/* rtl/core/cmap_format4_glyph_lookup.sv */
// cmap_format4_glyph_lookup: top level, character code to glyph index lookup
// depends on cmap4_pkg, cmap4_ctrl and cmap4_dp

// Load transactions (segment entry or glyph array word) keep busy low and give
// no result. A lookup scans the segments in order, one per cycle from the single
// read port of the segment memory, and stops at the first segment that holds the
// code; if none does, it reports no match. After a hit the glyph index comes from
// the delta, or, when the segment uses a range offset, from a glyph array read.
// The result shows for exactly one cycle with done high and is not held: the
// receiver must take it then. segment_count must be written only while busy is
// low; the block itself does not enforce this.
module cmap_format4_glyph_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [11:0]         slot,
  input  logic [20:0]         code,
  input  logic [15:0]         seg_start,
  input  logic [15:0]         seg_end,
  input  logic signed [15:0]  seg_delta,
  input  logic [15:0]         seg_range_offset,
  input  logic [15:0]         glyph_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data,
  output logic                done,
  output logic [15:0]         glyph_index,
  output logic                matched,
  output logic                index_error
);
  import cmap4_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cmap4_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cmap4_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .kind             (kind),
    .slot             (slot),
    .code             (code),
    .seg_start        (seg_start),
    .seg_end          (seg_end),
    .seg_delta        (seg_delta),
    .seg_range_offset (seg_range_offset),
    .glyph_word       (glyph_word),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .glyph_index      (glyph_index),
    .matched          (matched),
    .index_error      (index_error)
  );

  a_lookup_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_LOOKUP) |=> busy)
    else $error("lookup transaction did not raise busy");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a lookup");

  a_error_means_match: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (matched && glyph_index == 16'd0))
    else $error("index error without a matching segment or with a nonzero glyph");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (glyph_index == 16'd0))
    else $error("nonzero glyph without a matching segment");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for cmap_format4_glyph_lookup, with its own
// model of the segment table and glyph array; depends on cmap4_pkg and the rtl

module tb_top;
  import cmap4_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] slot;
    logic [20:0] code;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] delta;
    logic [15:0] ro;
    logic [15:0] word;
  } cmap_item_t;

  typedef struct packed {
    logic [20:0] code;
    logic [15:0] glyph;
    logic        hit;
    logic        err;
  } glyph_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic [11:0] slot;
  logic [20:0] code;
  logic [15:0] seg_start;
  logic [15:0] seg_end;
  logic signed [15:0] seg_delta;
  logic [15:0] seg_range_offset;
  logic [15:0] glyph_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [8:0] cfg_data;
  logic done;
  logic [15:0] glyph_index;
  logic matched;
  logic index_error;

  // model of the font tables
  logic [15:0] tbl_lo [MAX_SEGMENTS];
  logic [15:0] tbl_hi [MAX_SEGMENTS];
  logic [15:0] tbl_delta [MAX_SEGMENTS];
  logic [15:0] tbl_range [MAX_SEGMENTS];
  bit seg_loaded [MAX_SEGMENTS];
  logic [15:0] glyph_mem [GLYPH_WORDS];
  bit word_loaded [GLYPH_WORDS];
  logic [8:0] seg_count;

  glyph_result_t expected_glyphs[$];
  glyph_result_t want;
  int errors = 0;
  int idle_pct = 0;

  cmap_format4_glyph_lookup u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .slot(slot),
    .code(code),
    .seg_start(seg_start),
    .seg_end(seg_end),
    .seg_delta(seg_delta),
    .seg_range_offset(seg_range_offset),
    .glyph_word(glyph_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .glyph_index(glyph_index),
    .matched(matched),
    .index_error(index_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_segments();
    return (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
  endfunction

  // word_idx is the glyph array word the lookup reads, -1 if none
  function automatic glyph_result_t lookup_glyph(logic [20:0] c, output int word_idx);
    int cnt;
    int idx;
    logic [15:0] g;
    glyph_result_t r;
    cnt = active_segments();
    word_idx = -1;
    r = '0;
    r.code = c;
    for (int i = 0; i < cnt; i++) begin
      if (c >= tbl_lo[i] && c <= tbl_hi[i]) begin
        r.hit = 1'b1;
        if (tbl_range[i] == 16'd0) begin
          r.glyph = c[15:0] + tbl_delta[i];
        end else begin
          idx = int'(tbl_range[i] >> 1) + int'(c) - int'(tbl_lo[i]) + i - cnt;
          if (idx < 0 || idx >= GLYPH_WORDS) begin
            r.err = 1'b1;
          end else begin
            word_idx = idx;
            g = glyph_mem[idx];
            r.glyph = (g == 16'd0) ? 16'd0 : g + tbl_delta[i];
          end
        end
        return r;
      end
    end
    return r;
  endfunction

  task automatic update_font_model(cmap_item_t it);
    int w;
    case (it.kind)
      KIND_LOAD_SEG: begin
        if (it.slot < MAX_SEGMENTS) begin
          tbl_lo[it.slot] = it.lo;
          tbl_hi[it.slot] = it.hi;
          tbl_delta[it.slot] = it.delta;
          tbl_range[it.slot] = it.ro;
          seg_loaded[it.slot] = 1'b1;
        end
      end
      KIND_LOAD_WORD: begin
        glyph_mem[it.slot] = it.word;
        word_loaded[it.slot] = 1'b1;
      end
      KIND_LOOKUP: begin
        expected_glyphs.push_back(lookup_glyph(it.code, w));
      end
      default: ;
    endcase
  endtask

  function automatic cmap_item_t random_item();
    cmap_item_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.slot = 12'($urandom);
    it.code = 21'($urandom);
    it.lo = 16'($urandom);
    it.hi = 16'($urandom);
    it.delta = 16'($urandom);
    it.ro = 16'($urandom);
    it.word = 16'($urandom);
    return it;
  endfunction

  function automatic cmap_item_t seg_item(int s, logic [15:0] lo, logic [15:0] hi,
                                          logic [15:0] d, logic [15:0] ro);
    cmap_item_t it;
    it = random_item();
    it.kind = KIND_LOAD_SEG;
    it.slot = 12'(s);
    it.lo = lo;
    it.hi = hi;
    it.delta = d;
    it.ro = ro;
    return it;
  endfunction

  function automatic cmap_item_t word_item(int s, logic [15:0] value);
    cmap_item_t it;
    it = random_item();
    it.kind = KIND_LOAD_WORD;
    it.slot = 12'(s);
    it.word = value;
    return it;
  endfunction

  function automatic logic [15:0] random_word();
    return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  task automatic send_item(cmap_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= it.kind;
    slot <= it.slot;
    code <= it.code;
    seg_start <= it.lo;
    seg_end <= it.hi;
    seg_delta <= $signed(it.delta);
    seg_range_offset <= it.ro;
    glyph_word <= it.word;
    @(posedge clk);
    while (busy) @(posedge clk);
    update_font_model(it);
  endtask

  // a lookup never touches an entry that was not loaded first
  task automatic send_lookup(logic [20:0] c);
    int w;
    glyph_result_t r;
    cmap_item_t it;
    for (int i = 0; i < active_segments(); i++) begin
      if (!seg_loaded[i]) send_item(seg_item(i, 16'($urandom), 16'($urandom),
                                             16'($urandom), 16'($urandom)));
    end
    r = lookup_glyph(c, w);
    if (w >= 0 && !word_loaded[w]) send_item(word_item(w, random_word()));
    it = random_item();
    it.kind = KIND_LOOKUP;
    it.code = c;
    send_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_glyphs.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_segment_count(logic [8:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seg_count = value;
  endtask

  function automatic logic [20:0] pick_code();
    int i;
    int unsigned span;
    if (active_segments() == 0) return 21'($urandom);
    i = $urandom_range(0, active_segments() - 1);
    span = tbl_hi[i] - tbl_lo[i];
    case ($urandom_range(0, 19))
      0, 1, 2: return 21'($urandom_range(0, 16'hFFFF));
      3, 4:    return 21'($urandom);
      5:       return {5'd0, tbl_lo[i] - 16'd1};
      6:       return {5'd0, tbl_hi[i] + 16'd1};
      default: return 21'(tbl_lo[i] + $urandom_range(0, span));
    endcase
  endfunction

  // ascending, non-overlapping segments; most offset segments point inside the array, some get a random offset
  task automatic build_table(int n);
    int cnt;
    int cur;
    int s;
    int e;
    int b;
    logic [15:0] ro;
    cnt = active_segments();
    cur = $urandom_range(0, 300);
    for (int i = 0; i < n; i++) begin
      s = cur + $urandom_range(0, 200);
      e = s + (($urandom_range(0, 3) == 0) ? $urandom_range(41, 400) : $urandom_range(0, 40));
      if (e > 16'hFFFF || (i == n - 1 && $urandom_range(0, 3) == 0)) e = 16'hFFFF;
      case ($urandom_range(0, 7))
        0, 1, 2, 3: ro = 16'd0;
        7:          ro = 16'($urandom);
        default: begin
          if (e - s > 4000) begin
            ro = 16'd0;
          end else begin
            b = $urandom_range(0, GLYPH_WORDS - 1 - (e - s));
            ro = 16'(2 * (b - i + cnt) + $urandom_range(0, 1));
          end
        end
      endcase
      send_item(seg_item(i, 16'(s), 16'(e), 16'($urandom), ro));
      cur = e + 1;
    end
  endtask

  task automatic send_noise();
    cmap_item_t it;
    it = random_item();
    case ($urandom_range(0, 3))
      0: it.kind = KIND_UNUSED;
      1: begin
        it.kind = KIND_LOAD_SEG;
        it.slot = 12'($urandom_range(MAX_SEGMENTS, 4095));
      end
      2: it.kind = KIND_LOAD_WORD;
      default: begin
        // clobber a live segment with garbage
        it.kind = KIND_LOAD_SEG;
        it.slot = 12'($urandom_range(0, (active_segments() > 0) ? active_segments() - 1 : 0));
      end
    endcase
    send_item(it);
  endtask

  task automatic test_directed();
    cmap_item_t it;
    idle_pct = 0;
    send_lookup(21'h41);
    set_segment_count(9'd6);
    send_item(seg_item(0, 16'h0000, 16'h001F, 16'h8000, 16'h0000));
    send_item(seg_item(1, 16'h0020, 16'h007E, 16'h7FFF, 16'h0000));
    send_item(seg_item(2, 16'h00A0, 16'h00FF, 16'hFFE3, 16'h0008));
    send_item(seg_item(3, 16'h0100, 16'h01FF, 16'h0000, 16'h0002));
    send_item(seg_item(4, 16'h0200, 16'h02FF, 16'h0003, 16'h0011));
    send_item(seg_item(5, 16'h0300, 16'hFFFF, 16'h0001, 16'hFFFF));
    // segment slots past the table are dropped
    send_item(seg_item(4095, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    send_item(seg_item(MAX_SEGMENTS, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    send_item(word_item(0, 16'h0000));
    send_item(word_item(1, 16'h0010));
    send_item(word_item(16'h5F, 16'hFFFF));
    send_item(word_item(16'h16, 16'hAAAA));
    send_item(word_item(GLYPH_WORDS - 1, 16'h5555));
    it = random_item();
    it.kind = KIND_UNUSED;
    send_item(it);
    send_lookup(21'h0);
    send_lookup(21'h1F);
    send_lookup(21'h7E);
    send_lookup(21'h7F);
    send_lookup(21'hA0);
    send_lookup(21'hA1);
    send_lookup(21'hFF);
    send_lookup(21'h100);
    send_lookup(21'h210);
    send_lookup(21'hFFFF);
    send_lookup(21'h1FFFFF);
  endtask

  task automatic test_count_extremes();
    idle_pct = 9;
    set_segment_count(9'(MAX_SEGMENTS));
    build_table(MAX_SEGMENTS);
    repeat (20) send_lookup(pick_code());
    // counts past capacity scan the full table
    set_segment_count(9'h1FF);
    repeat (10) send_lookup(pick_code());
    set_segment_count(9'(MAX_SEGMENTS + 1));
    repeat (5) send_lookup(pick_code());
    set_segment_count(9'd0);
    repeat (4) send_lookup(21'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic test_random_tables(int pct, int budget);
    int sent;
    int n;
    idle_pct = pct;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      set_segment_count(9'(($urandom_range(0, 7) == 0) ? n + $urandom_range(1, 3) : n));
      build_table(n);
      sent += n;
      repeat ($urandom_range(8, 24)) begin
        case ($urandom_range(0, 15))
          0: send_noise();
          1: send_item(word_item($urandom_range(0, GLYPH_WORDS - 1), random_word()));
          default: send_lookup(pick_code());
        endcase
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_glyphs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: glyph %h matched %b error %b",
                   glyph_index, matched, index_error);
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_index !== want.glyph || matched !== want.hit ||
            index_error !== want.err) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch code %h: glyph %h/%h matched %b/%b error %b/%b (got/exp)",
                     want.code, glyph_index, want.glyph, matched, want.hit,
                     index_error, want.err);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_LOAD_SEG;
    slot <= '0;
    code <= '0;
    seg_start <= '0;
    seg_end <= '0;
    seg_delta <= '0;
    seg_range_offset <= '0;
    glyph_word <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    seg_count = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_count_extremes();
    test_random_tables(9, 180);
    test_random_tables(73, 180);
    test_random_tables(0, 180);
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
